>>> rtl/blg_pkg.sv
// Shared types and constants for the bond line geometry pipeline.
// Used by every module under rtl; it depends on nothing else.
`timescale 1ns / 1ps

package blg_pkg;

  localparam int COORD_W = 32;  // Q16.16 positions
  localparam int VEC_W   = 36;  // signed vector component fed to a normalizer
  localparam int MAG_W   = 36;  // magnitude of such a component
  localparam int SQ_IN_W = 30;  // component after the range shift
  localparam int SQ_W    = 60;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int SQRT_STEPS = 31;
  localparam int Q_W     = 17;  // quotient magnitude, at most 65536
  localparam int DIV_STEPS = 17;
  localparam int UNIT_W  = 18;  // signed Q2.16 unit component
  localparam int VIEW_W  = 18;
  localparam int PROD_W  = 36;
  localparam int OFS_W   = 20;
  localparam int OFFQ_W  = 21;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_VIEW_X      = 2'd0;
  localparam logic [IDX_W-1:0] REG_VIEW_Y      = 2'd1;
  localparam logic [IDX_W-1:0] REG_VIEW_Z      = 2'd2;
  localparam logic [IDX_W-1:0] REG_LINE_OFFSET = 2'd3;

  localparam logic signed [VIEW_W-1:0] VIEW_X_RESET = 18'sd0;
  localparam logic signed [VIEW_W-1:0] VIEW_Y_RESET = 18'sd0;
  localparam logic signed [VIEW_W-1:0] VIEW_Z_RESET = -18'sd65536;
  localparam logic [OFS_W-1:0] LINE_OFFSET_RESET = 20'd5243;

  localparam logic [2:0] ORDER_SINGLE = 3'd1;
  localparam logic [2:0] ORDER_DOUBLE = 3'd2;
  localparam logic [2:0] ORDER_TRIPLE = 3'd3;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_PLUS   = 2'd1;
  localparam logic [1:0] KIND_MINUS  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic [2:0]                bond_order;
  } bond_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic                      last_line;
  } line_t;

  typedef struct packed {
    logic adv;   // pipeline moves this cycle
    logic busy;  // holding stage has a bond
  } emit_stat_t;

endpackage

>>> rtl/blg_norm.sv
// Pipelined fixed-point vector normalizer: range shift, sum of squares,
// one integer square root bit per stage, one quotient bit per stage.
// Depends on blg_pkg. Takes one vector per cycle while en is high.
`timescale 1ns / 1ps

module blg_norm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  blg_pkg::bond_t                      in_side,
  input  logic signed [blg_pkg::VEC_W-1:0]    in_vec [3],
  output logic                                out_valid,
  output blg_pkg::bond_t                      out_side,
  output logic signed [blg_pkg::UNIT_W-1:0]   out_vec [3]
);
  import blg_pkg::*;

  // Stage A: magnitudes
  logic           a_valid;
  bond_t          a_side;
  logic [2:0]     a_neg;
  logic [MAG_W-1:0] a_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= in_side;
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][VEC_W-1];
        a_mag[i] <= in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
      end
    end
  end

  // Stage B: shift so that the largest magnitude is below 2^30
  logic [MAG_W-1:0] or_all;
  logic [2:0]       sh;
  logic             b_valid;
  bond_t            b_side;
  logic [2:0]       b_neg;
  logic [SQ_IN_W-1:0] b_m [3];

  always_comb begin
    or_all = a_mag[0] | a_mag[1] | a_mag[2];
    sh = 3'd0;
    for (int k = 1; k <= MAG_W - SQ_IN_W; k++) begin
      if (or_all[SQ_IN_W - 1 + k]) sh = 3'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      b_neg  <= a_neg;
      for (int i = 0; i < 3; i++) begin
        b_m[i] <= SQ_IN_W'(a_mag[i] >> sh);
      end
    end
  end

  // Stage C: squares
  logic           c_valid;
  bond_t          c_side;
  logic [2:0]     c_neg;
  logic [SQ_IN_W-1:0] c_m [3];
  logic [SQ_W-1:0]    c_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= b_side;
      c_neg  <= b_neg;
      c_m    <= b_m;
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= {{(SQ_W-SQ_IN_W){1'b0}}, b_m[i]} * {{(SQ_W-SQ_IN_W){1'b0}}, b_m[i]};
      end
    end
  end

  // Square root pipeline; index 0 is the sum stage
  logic             s_valid [0:SQRT_STEPS];
  bond_t            s_side  [0:SQRT_STEPS];
  logic [2:0]       s_neg   [0:SQRT_STEPS];
  logic [SQ_IN_W-1:0] s_m   [0:SQRT_STEPS][3];
  logic [SUM_W-1:0] s_x     [0:SQRT_STEPS];
  logic [SUM_W-1:0] s_r     [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side[0] <= c_side;
      s_neg[0]  <= c_neg;
      s_m[0]    <= c_m;
      s_x[0]    <= {2'b00, c_sq[0]} + {2'b00, c_sq[1]} + {2'b00, c_sq[2]};
      s_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SUM_W-1:0] trial;
    logic             take;

    assign trial = s_r[k] + BIT;
    assign take  = (s_x[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[k+1] <= 1'b0;
      end else if (en) begin
        s_valid[k+1] <= s_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_side[k+1] <= s_side[k];
        s_neg[k+1]  <= s_neg[k];
        s_m[k+1]    <= s_m[k];
        s_x[k+1]    <= take ? s_x[k] - trial : s_x[k];
        s_r[k+1]    <= take ? (s_r[k] >> 1) + BIT : (s_r[k] >> 1);
      end
    end
  end

  // Restoring division of (m << 16) by the root, one quotient bit per stage
  logic              d_valid [0:DIV_STEPS];
  bond_t             d_side  [0:DIV_STEPS];
  logic [2:0]        d_neg   [0:DIV_STEPS];
  logic [2:0]        d_lsb   [0:DIV_STEPS];
  logic              d_zero  [0:DIV_STEPS];
  logic [ROOT_W-1:0] d_len   [0:DIV_STEPS];
  logic [ROOT_W-1:0] d_rem   [0:DIV_STEPS][3];
  logic [Q_W-1:0]    d_q     [0:DIV_STEPS][3];

  // The top quotient bits are known to be zero, so the remainder starts
  // from the numerator without its low 17 bits.
  always_comb begin
    d_valid[0] = s_valid[SQRT_STEPS];
    d_side[0]  = s_side[SQRT_STEPS];
    d_neg[0]   = s_neg[SQRT_STEPS];
    d_len[0]   = s_r[SQRT_STEPS][ROOT_W-1:0];
    d_zero[0]  = (s_r[SQRT_STEPS][ROOT_W-1:0] == '0);
    for (int i = 0; i < 3; i++) begin
      d_lsb[0][i] = s_m[SQRT_STEPS][i][0];
      d_rem[0][i] = {{(ROOT_W-SQ_IN_W+1){1'b0}}, s_m[SQRT_STEPS][i][SQ_IN_W-1:1]};
      d_q[0][i]   = '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [ROOT_W:0]   t    [3];
    logic [ROOT_W-1:0] rem_n [3];
    logic [Q_W-1:0]    q_n  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {d_rem[j][i], (j == 0) ? d_lsb[j][i] : 1'b0};
        if (t[i] >= {1'b0, d_len[j]}) begin
          rem_n[i] = ROOT_W'(t[i] - {1'b0, d_len[j]});
          q_n[i]   = {d_q[j][i][Q_W-2:0], 1'b1};
        end else begin
          rem_n[i] = t[i][ROOT_W-1:0];
          q_n[i]   = {d_q[j][i][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[j+1] <= 1'b0;
      end else if (en) begin
        d_valid[j+1] <= d_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_side[j+1] <= d_side[j];
        d_neg[j+1]  <= d_neg[j];
        d_lsb[j+1]  <= d_lsb[j];
        d_zero[j+1] <= d_zero[j];
        d_len[j+1]  <= d_len[j];
        d_rem[j+1]  <= rem_n;
        d_q[j+1]    <= q_n;
      end
    end
  end

  // Sign and zero-length fixup
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= d_side[DIV_STEPS];
      for (int i = 0; i < 3; i++) begin
        if (d_zero[DIV_STEPS]) begin
          out_vec[i] <= '0;
        end else if (d_neg[DIV_STEPS][i]) begin
          out_vec[i] <= -$signed({1'b0, d_q[DIV_STEPS][i]});
        end else begin
          out_vec[i] <= $signed({1'b0, d_q[DIV_STEPS][i]});
        end
      end
    end
  end

endmodule

>>> rtl/blg_cross.sv
// Cross product of the unit bond direction with the view direction,
// two stages: registered products, then registered differences.
// Depends on blg_pkg.
`timescale 1ns / 1ps

module blg_cross (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  blg_pkg::bond_t                     in_side,
  input  logic signed [blg_pkg::UNIT_W-1:0]  in_vec [3],
  input  logic signed [blg_pkg::VIEW_W-1:0]  view_x,
  input  logic signed [blg_pkg::VIEW_W-1:0]  view_y,
  input  logic signed [blg_pkg::VIEW_W-1:0]  view_z,
  output logic                               out_valid,
  output blg_pkg::bond_t                     out_side,
  output logic signed [blg_pkg::VEC_W-1:0]   out_vec [3]
);
  import blg_pkg::*;

  logic  p_valid;
  bond_t p_side;
  logic signed [PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= in_side;
      p_yz   <= in_vec[1] * view_z;
      p_zy   <= in_vec[2] * view_y;
      p_zx   <= in_vec[2] * view_x;
      p_xz   <= in_vec[0] * view_z;
      p_xy   <= in_vec[0] * view_y;
      p_yx   <= in_vec[1] * view_x;
      out_side   <= p_side;
      out_vec[0] <= VEC_W'(p_yz - p_zy);
      out_vec[1] <= VEC_W'(p_zx - p_xz);
      out_vec[2] <= VEC_W'(p_xy - p_yx);
    end
  end

endmodule

>>> rtl/blg_emit.sv
// Side line offset, line endpoints, and the line sequencer with its output
// register. Produces the pipeline advance for all upstream stages.
// Depends on blg_pkg.
`timescale 1ns / 1ps

module blg_emit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  blg_pkg::bond_t                     in_side,
  input  logic signed [blg_pkg::UNIT_W-1:0]  in_vec [3],
  input  logic [blg_pkg::OFS_W-1:0]          line_offset,
  input  logic                               line_stall,
  output logic                               line_valid,
  output blg_pkg::line_t                     line,
  output blg_pkg::emit_stat_t                stat
);
  import blg_pkg::*;

  logic adv;

  // Offset magnitudes
  logic  o_valid;
  bond_t o_side;
  logic [2:0] o_neg;
  logic [OFFQ_W-1:0] o_q [3];
  logic [Q_W-1:0] n_mag [3];
  logic [Q_W+OFS_W-1:0] prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_mag[i] = in_vec[i][UNIT_W-1] ? Q_W'(-in_vec[i]) : Q_W'(in_vec[i]);
      prod[i]  = {{OFS_W{1'b0}}, n_mag[i]} * {{Q_W{1'b0}}, line_offset};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_side <= in_side;
      for (int i = 0; i < 3; i++) begin
        o_neg[i] <= in_vec[i][UNIT_W-1];
        o_q[i]   <= prod[i][Q_W+OFS_W-1:16];
      end
    end
  end

  // Endpoints for the center, plus and minus lines
  logic [COORD_W-1:0] o_a [3];
  logic [COORD_W-1:0] o_b [3];
  logic [COORD_W-1:0] off [3];

  always_comb begin
    o_a[0] = o_side.first_x;
    o_a[1] = o_side.first_y;
    o_a[2] = o_side.first_z;
    o_b[0] = o_side.second_x;
    o_b[1] = o_side.second_y;
    o_b[2] = o_side.second_z;
    for (int i = 0; i < 3; i++) begin
      off[i] = o_neg[i] ? -{{(COORD_W-OFFQ_W){1'b0}}, o_q[i]}
                        :  {{(COORD_W-OFFQ_W){1'b0}}, o_q[i]};
    end
  end

  logic       h_valid;
  logic [2:0] h_order;
  logic [COORD_W-1:0] h_a [3];
  logic [COORD_W-1:0] h_b [3];
  logic [COORD_W-1:0] h_ap [3];
  logic [COORD_W-1:0] h_bp [3];
  logic [COORD_W-1:0] h_am [3];
  logic [COORD_W-1:0] h_bm [3];
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_order <= o_side.bond_order;
      for (int i = 0; i < 3; i++) begin
        h_a[i]  <= o_a[i];
        h_b[i]  <= o_b[i];
        h_ap[i] <= o_a[i] + off[i];
        h_bp[i] <= o_b[i] + off[i];
        h_am[i] <= o_a[i] - off[i];
        h_bm[i] <= o_b[i] - off[i];
      end
    end
  end

  // Line sequencer
  logic [1:0] nl;
  logic [1:0] kind;
  logic       out_can, out_load, last, done;
  line_t      line_next;

  always_comb begin
    case (h_order)
      ORDER_SINGLE: nl = 2'd1;
      ORDER_DOUBLE: nl = 2'd2;
      ORDER_TRIPLE: nl = 2'd3;
      default:      nl = 2'd0;
    endcase
    // A double bond has no center line, so its sequence starts at the plus side.
    kind     = (h_order == ORDER_DOUBLE) ? cnt + 2'd1 : cnt;
    out_can  = !line_valid || !line_stall;
    out_load = h_valid && (nl != 2'd0) && out_can;
    last     = (cnt == nl - 2'd1);
    done     = h_valid && ((nl == 2'd0) || (out_can && last));
    adv      = !h_valid || done;
  end

  always_comb begin
    line_next.last_line = last;
    case (kind)
      KIND_PLUS: begin
        line_next.start_x = h_ap[0];
        line_next.start_y = h_ap[1];
        line_next.start_z = h_ap[2];
        line_next.end_x   = h_bp[0];
        line_next.end_y   = h_bp[1];
        line_next.end_z   = h_bp[2];
      end
      KIND_MINUS: begin
        line_next.start_x = h_am[0];
        line_next.start_y = h_am[1];
        line_next.start_z = h_am[2];
        line_next.end_x   = h_bm[0];
        line_next.end_y   = h_bm[1];
        line_next.end_z   = h_bm[2];
      end
      default: begin
        line_next.start_x = h_a[0];
        line_next.start_y = h_a[1];
        line_next.start_z = h_a[2];
        line_next.end_x   = h_b[0];
        line_next.end_y   = h_b[1];
        line_next.end_z   = h_b[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid    <= 1'b0;
      cnt        <= 2'd0;
      line_valid <= 1'b0;
    end else begin
      if (adv) begin
        h_valid <= o_valid;
        cnt     <= 2'd0;
      end else if (out_load) begin
        cnt <= cnt + 2'd1;
      end
      if (out_load) begin
        line_valid <= 1'b1;
      end else if (!line_stall) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line <= line_next;
    end
  end

  assign stat.adv  = adv;
  assign stat.busy = h_valid;

endmodule

>>> rtl/bond_line_geometry.sv
// Bond line generator. A bond transaction on the bond channel (bond_valid,
// bond_stall, bond) carries two Q16.16 endpoints and a bond order; the line
// channel (line_valid, line_stall, line) returns one transaction per drawn
// line: one for order 1, two for order 2, three for order 3, none otherwise,
// with last_line set on the final one. Configuration is written through
// cfg_write, cfg_index and cfg_data; the user must write it only while no
// bond is in flight, which the block itself does not enforce. The pipeline
// takes one bond per cycle while bond_stall is low; a bond stays in the
// holding stage until its last line is loaded into the output register, and
// the stages behind it wait. The output register sends one line per cycle
// while line_stall is low; a bond with no lines passes straight through.
// When line_stall holds a waiting line and the holding stage still has lines
// to send, the whole pipeline freezes in place and bond_stall rises; nothing
// is lost or repeated. Bubbles ahead of an empty holding stage keep moving.
// Synchronous reset empties every stage and loads the default view direction
// (0, 0, -1) and side line offset 0.08.
// Depends on blg_pkg, blg_norm, blg_cross and blg_emit.
`timescale 1ns / 1ps

module bond_line_geometry (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         bond_valid,
  output logic                         bond_stall,
  input  blg_pkg::bond_t               bond,
  output logic                         line_valid,
  input  logic                         line_stall,
  output blg_pkg::line_t               line,
  input  logic                         cfg_write,
  input  logic [blg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [blg_pkg::CFG_W-1:0]    cfg_data
);
  import blg_pkg::*;

  logic signed [VIEW_W-1:0] view_x, view_y, view_z;
  logic [OFS_W-1:0]         line_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x      <= VIEW_X_RESET;
      view_y      <= VIEW_Y_RESET;
      view_z      <= VIEW_Z_RESET;
      line_offset <= LINE_OFFSET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VIEW_X:      view_x      <= cfg_data[VIEW_W-1:0];
        REG_VIEW_Y:      view_y      <= cfg_data[VIEW_W-1:0];
        REG_VIEW_Z:      view_z      <= cfg_data[VIEW_W-1:0];
        REG_LINE_OFFSET: line_offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  emit_stat_t stat;
  logic       adv;

  assign adv        = stat.adv;
  assign bond_stall = !adv;

  // Bond direction, not yet normalized
  logic  in_valid;
  bond_t in_side;
  logic signed [VEC_W-1:0] in_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= bond_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_side <= bond;
      in_d[0] <= VEC_W'(33'(bond.second_x) - 33'(bond.first_x));
      in_d[1] <= VEC_W'(33'(bond.second_y) - 33'(bond.first_y));
      in_d[2] <= VEC_W'(33'(bond.second_z) - 33'(bond.first_z));
    end
  end

  logic  u_valid;
  bond_t u_side;
  logic signed [UNIT_W-1:0] u_vec [3];

  blg_norm u_norm_dir (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .in_side   (in_side),
    .in_vec    (in_d),
    .out_valid (u_valid),
    .out_side  (u_side),
    .out_vec   (u_vec)
  );

  logic  c_valid;
  bond_t c_side;
  logic signed [VEC_W-1:0] c_vec [3];

  blg_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (u_valid),
    .in_side   (u_side),
    .in_vec    (u_vec),
    .view_x    (view_x),
    .view_y    (view_y),
    .view_z    (view_z),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_vec   (c_vec)
  );

  logic  n_valid;
  bond_t n_side;
  logic signed [UNIT_W-1:0] n_vec [3];

  blg_norm u_norm_nrm (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .in_vec    (c_vec),
    .out_valid (n_valid),
    .out_side  (n_side),
    .out_vec   (n_vec)
  );

  blg_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (n_valid),
    .in_side     (n_side),
    .in_vec      (n_vec),
    .line_offset (line_offset),
    .line_stall  (line_stall),
    .line_valid  (line_valid),
    .line        (line),
    .stat        (stat)
  );

`ifndef NO_ASSERTIONS
  // Nothing is offered on the line channel right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !line_valid)
    else $error("line channel valid right after reset");

  // Once a line that is not the last of its bond is taken, the next one follows.
  a_lines_follow: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_stall && !line.last_line |=> line_valid)
    else $error("gap inside the lines of one bond");

  // The bond channel stalls only while the holding stage has a bond.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    bond_stall |-> stat.busy)
    else $error("bond channel stalled with an empty holding stage");
`endif

endmodule

>>> bench/bond_line_geometry_tb.sv
// Self-checking bench for bond_line_geometry: random and directed bonds are
// driven through the bond channel and every line is checked against a
// built-in Q16.16 line predictor. Depends on blg_pkg and the RTL only.
`timescale 1ns / 1ps

module bond_line_geometry_tb;
  import blg_pkg::*;

  typedef longint signed trio_t [0:2];

  localparam int LIMIT = 400000;
  localparam int SETTLE = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic bond_valid = 1'b0;
  logic bond_stall;
  bond_t bond = '0;
  logic line_valid;
  logic line_stall = 1'b0;
  line_t line;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_VIEW_X;
  logic [CFG_W-1:0] cfg_data = '0;

  bond_line_geometry dut (
    .clk(clk), .rst(rst),
    .bond_valid(bond_valid), .bond_stall(bond_stall), .bond(bond),
    .line_valid(line_valid), .line_stall(line_stall), .line(line),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  bond_t bond_backlog[$];
  line_t line_fifo[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  bit taken = 1'b0;

  // Shadow copies of the configuration registers.
  logic signed [VIEW_W-1:0] view_x_q = VIEW_X_RESET;
  logic signed [VIEW_W-1:0] view_y_q = VIEW_Y_RESET;
  logic signed [VIEW_W-1:0] view_z_q = VIEW_Z_RESET;
  logic [OFS_W-1:0] offset_q = LINE_OFFSET_RESET;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic trio_t unit_vector(trio_t v);
    longint unsigned m [0:2];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint signed q;
    trio_t res;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        res[i] = 0;
      end else begin
        q = longint'((m[i] << 16) / len);
        res[i] = (v[i] < 0) ? -q : q;
      end
    end
    return res;
  endfunction

  function automatic line_t make_line(bond_t b, trio_t ofs, bit neg, bit last);
    line_t l;
    logic [31:0] d [0:2];
    for (int i = 0; i < 3; i++) d[i] = neg ? -ofs[i][31:0] : ofs[i][31:0];
    l.start_x = b.first_x + d[0];
    l.start_y = b.first_y + d[1];
    l.start_z = b.first_z + d[2];
    l.end_x = b.second_x + d[0];
    l.end_y = b.second_y + d[1];
    l.end_z = b.second_z + d[2];
    l.last_line = last;
    return l;
  endfunction

  function automatic void expect_line(line_t l);
    line_fifo = {line_fifo, l};
  endfunction

  // Works out the lines that one bond draws and queues them in order.
  function automatic void predict_lines(bond_t b);
    trio_t dir;
    trio_t u;
    trio_t c;
    trio_t n;
    trio_t ofs;
    trio_t none;
    longint signed vx;
    longint signed vy;
    longint signed vz;
    longint signed q;
    vx = view_x_q;
    vy = view_y_q;
    vz = view_z_q;
    dir[0] = longint'(b.second_x) - longint'(b.first_x);
    dir[1] = longint'(b.second_y) - longint'(b.first_y);
    dir[2] = longint'(b.second_z) - longint'(b.first_z);
    u = unit_vector(dir);
    c[0] = u[1] * vz - u[2] * vy;
    c[1] = u[2] * vx - u[0] * vz;
    c[2] = u[0] * vy - u[1] * vx;
    n = unit_vector(c);
    for (int i = 0; i < 3; i++) begin
      q = ((n[i] < 0 ? -n[i] : n[i]) * longint'({1'b0, offset_q})) >>> 16;
      ofs[i] = (n[i] < 0) ? -q : q;
      none[i] = 0;
    end
    case (b.bond_order)
      ORDER_SINGLE: expect_line(make_line(b, none, 1'b0, 1'b1));
      ORDER_DOUBLE: begin
        expect_line(make_line(b, ofs, 1'b0, 1'b0));
        expect_line(make_line(b, ofs, 1'b1, 1'b1));
      end
      ORDER_TRIPLE: begin
        expect_line(make_line(b, none, 1'b0, 1'b0));
        expect_line(make_line(b, ofs, 1'b0, 1'b0));
        expect_line(make_line(b, ofs, 1'b1, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // Driver: a stalled transaction holds its payload until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      bond_valid <= 1'b0;
    end else if (!bond_valid || taken) begin
      if (bond_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        bond <= bond_backlog.pop_front();
        bond_valid <= 1'b1;
      end else begin
        bond_valid <= 1'b0;
      end
    end
    taken = 1'b0;
    line_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor: predicts on each accepted bond and checks each accepted line.
  always @(posedge clk) begin
    line_t exp_l;
    cycles++;
    if (cycles == LIMIT) begin
      $display("bond_line_geometry regression: fail");
      $finish;
    end
    if (!rst) begin
      if (bond_valid && !bond_stall) begin
        taken = 1'b1;
        predict_lines(bond);
      end
      if (line_valid && !line_stall) begin
        if (line_fifo.size() == 0) begin
          $error("unexpected line transaction");
          errors++;
        end else begin
          exp_l = line_fifo.pop_front();
          if (line.start_x !== exp_l.start_x) begin
            $error("start_x expected %h actual %h", exp_l.start_x, line.start_x);
            errors++;
          end
          if (line.start_y !== exp_l.start_y) begin
            $error("start_y expected %h actual %h", exp_l.start_y, line.start_y);
            errors++;
          end
          if (line.start_z !== exp_l.start_z) begin
            $error("start_z expected %h actual %h", exp_l.start_z, line.start_z);
            errors++;
          end
          if (line.end_x !== exp_l.end_x) begin
            $error("end_x expected %h actual %h", exp_l.end_x, line.end_x);
            errors++;
          end
          if (line.end_y !== exp_l.end_y) begin
            $error("end_y expected %h actual %h", exp_l.end_y, line.end_y);
            errors++;
          end
          if (line.end_z !== exp_l.end_z) begin
            $error("end_z expected %h actual %h", exp_l.end_z, line.end_z);
            errors++;
          end
          if (line.last_line !== exp_l.last_line) begin
            $error("last_line expected %b actual %b", exp_l.last_line, line.last_line);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_VIEW_X: view_x_q = value[VIEW_W-1:0];
      REG_VIEW_Y: view_y_q = value[VIEW_W-1:0];
      REG_VIEW_Z: view_z_q = value[VIEW_W-1:0];
      REG_LINE_OFFSET: offset_q = value[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(int vx, int vy, int vz, int ofs);
    write_reg(REG_VIEW_X, CFG_W'(vx));
    write_reg(REG_VIEW_Y, CFG_W'(vy));
    write_reg(REG_VIEW_Z, CFG_W'(vz));
    write_reg(REG_LINE_OFFSET, CFG_W'(ofs));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every bond is sent and every line has come back, then lets
  // bonds that draw nothing leave the pipeline too.
  task automatic drain();
    while (bond_backlog.size() != 0 || bond_valid || line_fifo.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32 * 65536) - 16 * 65536;
  endfunction

  task automatic add_bond(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                          logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                          logic [2:0] ord);
    bond_t b;
    b = '{ax, ay, az, bx, by, bz, ord};
    bond_backlog = {bond_backlog, b};
  endtask

  task automatic add_random(int count);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [2:0] ord;
    for (int i = 0; i < count; i++) begin
      ax = rand_coord();
      ay = rand_coord();
      az = rand_coord();
      // Mostly drawn orders; the rest take any order code, drawn or not.
      ord = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 3))
                                       : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0: add_bond(ax, ay, az, ax, ay, az, ord);
        1: add_bond(ax, ay, az, ax, ay, az + $urandom_range(1, 1 << 20), ord);
        default: add_bond(ax, ay, az, rand_coord(), rand_coord(), rand_coord(), ord);
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bonds under the reset view.
    send_idle_pct = 24;
    recv_idle_pct = 87;
    for (int o = 0; o < 8; o++)
      add_bond(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, o[2:0]);
    add_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ORDER_TRIPLE);
    add_bond(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'hFFFF_FFFF, ORDER_DOUBLE);
    add_bond(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
             32'h1234_5678, 32'h1234_5678, 32'h1234_5678, ORDER_TRIPLE);
    add_bond(0, 0, 0, 0, 0, 32'h0003_0000, ORDER_TRIPLE);
    add_bond(32'h7FFF_0000, 0, 0, 32'h8001_0000, 32'h0000_8000, 0, ORDER_DOUBLE);
    add_bond(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001,
             32'hFFFF_FFFF, 32'h8000_0000, ORDER_SINGLE);
    drain();

    set_view(65536, 0, 0, 1048575);
    add_bond(0, 0, 0, 32'h0005_0000, 0, 0, ORDER_TRIPLE);
    add_bond(0, 0, 0, 0, 32'h0005_0000, 0, ORDER_DOUBLE);
    add_random(80);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 24;
    set_view(-65536, 0, 0, 0);
    add_random(80);
    drain();

    set_view(0, 0, 0, $urandom_range(0, 1048575));
    add_random(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_view($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
             $urandom_range(0, 131072) - 65536, $urandom_range(0, 1048575));
    add_random(80);
    drain();

    set_view(0, 65536, 0, $urandom_range(0, 65536));
    add_random(80);
    drain();

    set_view($urandom(), $urandom(), $urandom(), $urandom());
    add_random(60);
    drain();

    if (errors == 0)
      $display("bond_line_geometry regression: pass");
    else
      $display("bond_line_geometry regression: fail");
    $finish;
  end

endmodule
